### sv/dip_pkg.sv
package dip_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_DIGITS = 2'd1,
    ST_RANGE     = 2'd2
  } status_e;

  // Parser phases
  localparam logic [1:0] PH_BLANK  = 2'd0;  // skipping blanks
  localparam logic [1:0] PH_SIGN   = 2'd1;  // sign taken, no digit yet
  localparam logic [1:0] PH_DIGITS = 2'd2;  // inside a digit run
  localparam logic [1:0] PH_DROP   = 2'd3;  // dropping an overlong digit run

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;

  localparam int unsigned MAG_W = 31;
  localparam int unsigned VAL_W = 32;
  localparam logic [MAG_W-1:0] LIMIT_RESET = 31'h7fff_ffff;

  // Result queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  typedef struct packed {
    logic [1:0]       phase;
    logic [MAG_W-1:0] mag;
    logic             neg;
  } dip_state_t;

  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
    status_e          status;
  } dip_res_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    status_e          status;
    logic             last;
  } dip_entry_t;

endpackage

### sv/decimal_integer_parser.sv
// Channel   | Dir | Handshake                   | Payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready | tdata char_code, tlast end_of_stream
// m_axis    | out | m_axis_tvalid/m_axis_tready | tdata number_value, tuser status,
//           |     |                             | tlast last_of_item
// cfg       | in  | cfg_valid_i/cfg_ready_o     | cfg_data_i max_magnitude
//
// A character is taken into the input register, parsed from there when the queue has
// room, and its results (none, one or two) are written to a four-entry result queue.
// One character per cycle is sustained while the output accepts; the rate is
// bounded by the single output port, which drains one result per cycle, so a
// character giving two results takes the port for both. Parsing stalls while
// the queue has fewer than two free entries. Reset clears the parser to skipping
// blanks, empties the queue and sets the limit to 2147483647.
module decimal_integer_parser import dip_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] char_code
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [VAL_W-1:0] m_axis_tdata,   // [31:0] number_value
  output logic [1:0]       m_axis_tuser,   // [1:0] status
  output logic             m_axis_tlast,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [MAG_W-1:0] cfg_data_i      // [30:0] max_magnitude
);

  logic [MAG_W-1:0]  limit_q;
  logic              in_valid_q;
  logic [7:0]        char_q;
  logic              eos_q;
  dip_state_t        state_q;
  dip_state_t        state_d;
  dip_res_t          res0;
  dip_res_t          res1;
  logic [1:0]        nres;
  logic              step_fire;
  logic              pop;
  dip_entry_t        mem_q [QDEPTH];
  logic [QPTR_W-1:0] wp_q;
  logic [QPTR_W-1:0] rp_q;
  logic [QCNT_W-1:0] cnt_q;
  logic [QPTR_W-1:0] wp_next;

  // Limit register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Parse only when at least two queue entries are free
  assign step_fire     = in_valid_q && (cnt_q <= QCNT_W'(QDEPTH - 2));
  assign s_axis_tready = !in_valid_q || step_fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      char_q <= s_axis_tdata;
      eos_q  <= s_axis_tlast;
    end
  end

  dip_step u_step (
    .state_i (state_q),
    .char_i  (char_q),
    .eos_i   (eos_q),
    .limit_i (limit_q),
    .state_o (state_d),
    .res0_o  (res0),
    .res1_o  (res1),
    .nres_o  (nres)
  );

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_fire) begin
      state_q <= state_d;
    end
  end

  // Result queue
  assign pop     = m_axis_tvalid && m_axis_tready;
  assign wp_next = wp_q + QPTR_W'(1);

  always_ff @(posedge clk_i) begin
    if (step_fire && (nres != 2'd0)) begin
      mem_q[wp_q] <= '{value: res0.value, status: res0.status, last: (nres == 2'd1)};
    end
    if (step_fire && (nres == 2'd2)) begin
      mem_q[wp_next] <= '{value: res1.value, status: res1.status, last: 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (step_fire) begin
        wp_q <= wp_q + QPTR_W'(nres);
      end
      if (pop) begin
        rp_q <= rp_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + (step_fire ? QCNT_W'(nres) : '0) - QCNT_W'(pop);
    end
  end

  assign m_axis_tvalid = cnt_q != '0;
  assign m_axis_tdata  = mem_q[rp_q].value;
  assign m_axis_tuser  = 2'(mem_q[rp_q].status);
  assign m_axis_tlast  = mem_q[rp_q].last;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH)) else $error("result queue count beyond depth");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire |-> (cnt_q + QCNT_W'(nres) <= QCNT_W'(QDEPTH)))
    else $error("result queue overrun");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != 2'(ST_OK))) |-> (m_axis_tdata == '0))
    else $error("error result carries a nonzero value");

  a_drop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_DROP) |-> ((state_q.mag == '0) && !state_q.neg))
    else $error("dropping phase holds a magnitude");

  a_mag_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && (state_d.phase == PH_DIGITS)) |=> (state_q.mag <= $past(limit_q)))
    else $error("accumulated magnitude above limit");

endmodule

### sv/dip_step.sv
module dip_step import dip_pkg::*; (
  input  dip_state_t       state_i,
  input  logic [7:0]       char_i,
  input  logic             eos_i,
  input  logic [MAG_W-1:0] limit_i,
  output dip_state_t       state_o,
  output dip_res_t         res0_o,
  output dip_res_t         res1_o,
  output logic [1:0]       nres_o
);

  logic             is_digit;
  logic             is_blank;
  logic             is_sign;
  logic [MAG_W+3:0] prod;
  logic             over;
  logic [VAL_W-1:0] sval;
  dip_res_t         ra;
  dip_res_t         rb;

  // Character classes
  assign is_digit = char_i inside {[CH_ZERO:CH_NINE]};
  assign is_blank = char_i inside {CH_SPACE, CH_TAB, CH_NL};
  assign is_sign  = (char_i == CH_PLUS) || (char_i == CH_MINUS);

  // magnitude * 10 + digit, then limit check
  assign prod = ({4'b0, state_i.mag} << 3) + ({4'b0, state_i.mag} << 1)
              + {{(MAG_W){1'b0}}, char_i[3:0]};
  assign over = prod > {4'b0, limit_i};

  assign sval = state_i.neg ? (32'd0 - {1'b0, state_i.mag}) : {1'b0, state_i.mag};

  // One character step; ra comes from the current phase, rb from a fresh start
  always_comb begin
    state_o = state_i;
    ra      = '{valid: 1'b0, value: '0, status: ST_OK};
    rb      = '{valid: 1'b0, value: '0, status: ST_OK};
    if (eos_i) begin
      case (state_i.phase)
        PH_DIGITS: ra = '{valid: 1'b1, value: sval, status: ST_OK};
        PH_SIGN:   ra = '{valid: 1'b1, value: '0, status: ST_NO_DIGITS};
        default: ;
      endcase
      state_o = '0;
    end else if (is_digit) begin
      if (state_i.phase != PH_DROP) begin
        if (over) begin
          ra      = '{valid: 1'b1, value: '0, status: ST_RANGE};
          state_o = '{phase: PH_DROP, mag: '0, neg: 1'b0};
        end else begin
          state_o = '{phase: PH_DIGITS, mag: prod[MAG_W-1:0], neg: state_i.neg};
        end
      end
    end else begin
      // close whatever was pending
      case (state_i.phase)
        PH_SIGN:   ra = '{valid: 1'b1, value: '0, status: ST_NO_DIGITS};
        PH_DIGITS: ra = '{valid: 1'b1, value: sval, status: ST_OK};
        default: ;
      endcase
      // then treat the character as the start of a new number
      state_o = '0;
      if (is_sign) begin
        state_o = '{phase: PH_SIGN, mag: '0, neg: (char_i == CH_MINUS)};
      end else if (!is_blank) begin
        rb = '{valid: 1'b1, value: '0, status: ST_NO_DIGITS};
      end
    end
  end

  // Compact so the first valid result leads
  assign res0_o = ra.valid ? ra : rb;
  assign res1_o = rb;
  assign nres_o = {1'b0, ra.valid} + {1'b0, rb.valid};

endmodule

### bench/decimal_integer_parser_tb.sv
module decimal_integer_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dip_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 8;

  // One parsed number or error as it leaves the block
  typedef struct {
    logic [VAL_W-1:0] value;
    status_e          status;
    logic             last;
  } parse_result_t;

  // Hand-written expectation riding along with a character (count 0 or 1)
  typedef struct {
    bit               typed;
    int               count;
    logic [VAL_W-1:0] value;
    status_e          status;
  } typed_result_t;

  typedef struct {
    logic [7:0]       ch;
    logic             eos;
    bit               typed;
    int               count;
    logic [VAL_W-1:0] value;
    status_e          status;
  } char_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;   // [7:0] char_code
  logic             s_axis_tlast;   // end_of_stream
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [VAL_W-1:0] m_axis_tdata;   // [31:0] number_value
  logic [1:0]       m_axis_tuser;   // [1:0] status
  logic             m_axis_tlast;   // last_of_item
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [MAG_W-1:0] cfg_data_i;     // [30:0] max_magnitude

  decimal_integer_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  parse_result_t expected_numbers[$];
  typed_result_t typed_notes[$];
  char_row_t     char_table[$];

  int mismatches   = 0;
  int cycles       = 0;
  int chars_sent   = 0;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int rx_hold_left = 0;

  // Parser mirror
  logic [1:0]       psr_phase;
  logic [MAG_W-1:0] psr_mag;
  logic             psr_neg;
  logic [MAG_W-1:0] psr_limit;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random back-pressure, or a long hold when one is requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_left > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void add_number(logic [VAL_W-1:0] v, status_e s);
    expected_numbers.push_back('{value: v, status: s, last: 1'b0});
  endfunction

  function automatic void clear_number();
    psr_phase = PH_BLANK;
    psr_mag   = '0;
    psr_neg   = 1'b0;
  endfunction

  function automatic logic [VAL_W-1:0] signed_number();
    logic [VAL_W-1:0] m;
    m = {1'b0, psr_mag};
    return psr_neg ? (32'd0 - m) : m;
  endfunction

  function automatic void take_digit(logic [7:0] c);
    longint unsigned t;
    t = 64'(psr_mag) * 64'd10 + 64'(c - CH_ZERO);
    if (t > 64'(psr_limit)) begin
      add_number('0, ST_RANGE);
      psr_mag   = '0;
      psr_neg   = 1'b0;
      psr_phase = PH_DROP;
    end else begin
      psr_mag   = t[MAG_W-1:0];
      psr_phase = PH_DIGITS;
    end
  endfunction

  // Returns 1 when the character has to be looked at again from blank phase
  function automatic bit parse_char(logic [7:0] c);
    case (psr_phase)
      PH_BLANK: begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_NL) return 1'b0;
        if (c == CH_PLUS || c == CH_MINUS) begin
          psr_neg   = (c == CH_MINUS);
          psr_mag   = '0;
          psr_phase = PH_SIGN;
          return 1'b0;
        end
        if (is_digit(c)) begin
          psr_mag = '0;
          take_digit(c);
          return 1'b0;
        end
        add_number('0, ST_NO_DIGITS);
        return 1'b0;
      end
      PH_SIGN: begin
        if (is_digit(c)) begin
          take_digit(c);
          return 1'b0;
        end
        add_number('0, ST_NO_DIGITS);
        clear_number();
        return 1'b1;
      end
      PH_DIGITS: begin
        if (is_digit(c)) begin
          take_digit(c);
          return 1'b0;
        end
        add_number(signed_number(), ST_OK);
        clear_number();
        return 1'b1;
      end
      default: begin
        if (is_digit(c)) return 1'b0;
        clear_number();
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void predict_numbers(logic [7:0] c, logic eos);
    int            n_prior;
    parse_result_t tail;
    n_prior = expected_numbers.size();
    if (eos) begin
      if (psr_phase == PH_DIGITS) add_number(signed_number(), ST_OK);
      else if (psr_phase == PH_SIGN) add_number('0, ST_NO_DIGITS);
      clear_number();
    end else if (parse_char(c)) begin
      void'(parse_char(c));
    end
    if (expected_numbers.size() > n_prior) begin
      tail = expected_numbers.pop_back();
      tail.last = 1'b1;
      expected_numbers.push_back(tail);
    end
  endfunction

  // Scoreboard: results first, then the character taken at this edge
  always @(posedge clk_i) begin : scoreboard
    parse_result_t want;
    typed_result_t note;
    int            n_prior;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_numbers.size() == 0) begin
          $error("unexpected result: number_value %0d status %0d last_of_item %0b",
                 $signed(m_axis_tdata), m_axis_tuser, m_axis_tlast);
          mismatches++;
        end else begin
          want = expected_numbers.pop_front();
          if (m_axis_tdata !== want.value) begin
            $error("number_value: expected %0d, got %0d",
                   $signed(want.value), $signed(m_axis_tdata));
            mismatches++;
          end
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
            mismatches++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_of_item: expected %0b, got %0b", want.last, m_axis_tlast);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        note    = typed_notes.pop_front();
        n_prior = expected_numbers.size();
        predict_numbers(s_axis_tdata, s_axis_tlast);
        // hand-written rows replace what the mirror worked out
        if (note.typed) begin
          while (expected_numbers.size() > n_prior) void'(expected_numbers.pop_back());
          if (note.count > 0)
            expected_numbers.push_back('{value: note.value, status: note.status, last: 1'b1});
        end
      end
    end
  end

  // One character transfer, with a random gap in front
  task automatic send_char(logic [7:0] ch, logic eos, bit typed = 1'b0, int count = 0,
                           logic [VAL_W-1:0] value = '0, status_e status = ST_OK);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    typed_notes.push_back('{typed: typed, count: count, value: value, status: status});
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    chars_sent++;
  endtask

  // Hold the input until every expected number is out, then let the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_numbers.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [MAG_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    psr_limit = v;
  endtask

  function automatic logic [7:0] any_blank();
    case ($urandom_range(2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_NL;
    endcase
  endfunction

  function automatic logic [7:0] any_non_digit();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (is_digit(c));
    return c;
  endfunction

  // Blanks, optional sign, a digit run, then something that ends it
  task automatic send_number_text();
    longint unsigned v;
    string           s;
    int              k;
    repeat ($urandom_range(2)) send_char(any_blank(), 1'b0);
    if ($urandom_range(2) == 0) send_char($urandom_range(1) ? CH_MINUS : CH_PLUS, 1'b0);
    case ($urandom_range(9))
      0: v = 64'(psr_limit);
      1: v = 64'(psr_limit) + 64'd1;
      2: v = (psr_limit == '0) ? 64'd0 : 64'(psr_limit) - 64'd1;
      3: v = {$urandom, $urandom} % (64'(psr_limit) * 2 + 2);
      4: v = {$urandom, $urandom} % 64'd100000000000000;
      default: v = 64'($urandom_range(99999));
    endcase
    s = $sformatf("%0d", v);
    if ($urandom_range(7) == 0) s = {"0", s};
    for (k = 0; k < s.len(); k++) send_char(s[k], 1'b0);
    case ($urandom_range(4))
      0:       send_char(any_blank(), 1'b0);
      1:       send_char($urandom_range(1) ? CH_MINUS : CH_PLUS, 1'b0);
      2:       send_char(any_non_digit(), 1'b0);
      3:       send_char(8'($urandom_range(255)), 1'b1);
      default: send_char(",", 1'b0);
    endcase
  endtask

  // Stray bytes, bare ends of stream and signs with nothing behind them
  task automatic send_noise();
    case ($urandom_range(3))
      0: send_char(8'($urandom_range(255)), 1'b0);
      1: send_char(8'($urandom_range(255)), 1'b1);
      2: begin
        send_char($urandom_range(1) ? CH_MINUS : CH_PLUS, 1'b0);
        send_char(any_non_digit(), $urandom_range(3) == 0);
      end
      default: send_char(any_blank(), 1'b0);
    endcase
  endtask

  task automatic run_phase(int n_chars, int tx_pct, int rx_pct, bit pressure);
    int  start;
    bit  held;
    bit  paused;
    start  = chars_sent;
    held   = 1'b0;
    paused = 1'b0;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (chars_sent - start < n_chars) begin
      if ($urandom_range(99) < 15) send_noise();
      else send_number_text();
      if (pressure && !held && chars_sent - start > n_chars / 2) begin
        // receiver stalls while characters keep coming: the block must back up
        rx_hold_left = 300;
        held = 1'b1;
      end
      if (pressure && !paused && chars_sent - start > 3 * n_chars / 4) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (expected_numbers.size() != 0);
        paused = 1'b1;
      end
    end
    send_char(8'h00, 1'b1);
    drain();
  endtask

  function automatic char_row_t row(logic [7:0] ch, logic eos, bit typed = 1'b0,
                                    int count = 0, logic [VAL_W-1:0] value = '0,
                                    status_e status = ST_OK);
    return '{ch: ch, eos: eos, typed: typed, count: count, value: value, status: status};
  endfunction

  initial begin : stimulus
    string edge_digits;
    int    k;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    m_axis_tready <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    rst_ni        <= 1'b0;
    psr_limit = LIMIT_RESET;
    clear_number();

    // stray characters, field extremes, blanks
    char_table.push_back(row("x", 1'b0, 1'b1, 1, '0, ST_NO_DIGITS));
    char_table.push_back(row(8'hff, 1'b0, 1'b1, 1, '0, ST_NO_DIGITS));
    char_table.push_back(row(8'h00, 1'b0, 1'b1, 1, '0, ST_NO_DIGITS));
    char_table.push_back(row(CH_TAB, 1'b0, 1'b1, 0));
    // negative zero
    char_table.push_back(row(CH_MINUS, 1'b0));
    char_table.push_back(row(CH_ZERO, 1'b0));
    char_table.push_back(row(CH_SPACE, 1'b0, 1'b1, 1, '0, ST_OK));
    // sign with no digits: the terminator is also a stray, two results
    char_table.push_back(row(CH_PLUS, 1'b0));
    char_table.push_back(row(";", 1'b0));
    // end of stream after a bare sign, then on an empty parser
    char_table.push_back(row(CH_MINUS, 1'b0));
    char_table.push_back(row("5", 1'b1, 1'b1, 1, '0, ST_NO_DIGITS));
    char_table.push_back(row(8'h00, 1'b1, 1'b1, 0));
    // one past the reset limit overflows on its last digit
    edge_digits = "214748364";
    for (k = 0; k < edge_digits.len(); k++) char_table.push_back(row(edge_digits[k], 1'b0));
    char_table.push_back(row("8", 1'b0, 1'b1, 1, '0, ST_RANGE));
    char_table.push_back(row("9", 1'b0, 1'b1, 0));
    char_table.push_back(row(CH_PLUS, 1'b0, 1'b1, 0));
    char_table.push_back(row("5", 1'b0));
    char_table.push_back(row(8'h00, 1'b1, 1'b1, 1, 32'd5, ST_OK));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 26;
    rx_idle_pct = 87;
    foreach (char_table[i])
      send_char(char_table[i].ch, char_table[i].eos, char_table[i].typed,
                char_table[i].count, char_table[i].value, char_table[i].status);
    drain();

    run_phase(480, 26, 87, 1'b1);
    write_limit(31'($urandom_range(1, 999999)));
    run_phase(480, 87, 26, 1'b0);
    write_limit(31'd1);
    run_phase(200, 0, 0, 1'b0);
    write_limit(31'd0);
    run_phase(150, 0, 0, 1'b0);
    write_limit(31'h7fff_ffff);
    run_phase(450, 0, 0, 1'b0);

    // everything is already drained; allow for stragglers
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_numbers.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
